@@ rtl/core/fragment_reassembly_slots_defines.svh @@
// Assertion macros for the fragment reassembly block.
// No dependencies; included by the top level.
`ifndef FRAGMENT_REASSEMBLY_SLOTS_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_SLOTS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define FRA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fra check failed");
// next-cycle implication, disabled in reset
`define FRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fra check failed");
`else
`define FRA_ASSERT_NOW(label, ante, cons)
`define FRA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/fra_pkg.sv @@
// Shared types, codes and defaults for the fragment reassembly block.
// No dependencies.
package fra_pkg;

  localparam int SLOT_COUNT_DEF  = 4;
  localparam int STORE_BYTES_DEF = 4096;
  localparam int HDR_BYTES       = 16;

  typedef enum logic [1:0] {
    OP_HEADER  = 2'd0,
    OP_BYTE    = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_BAD_HDR  = 3'd0,
    KIND_NO_SLOT  = 3'd1,
    KIND_WHOLE    = 3'd2,
    KIND_STORED   = 3'd3,
    KIND_COMPLETE = 3'd4,
    KIND_PASS     = 3'd5,
    KIND_READ     = 3'd6,
    KIND_RELEASED = 3'd7
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] frag_len;
    logic [31:0] seq_id;
    logic [31:0] frag_size;
    logic [31:0] frag_offset;
    logic [31:0] msg_total;
    logic [7:0]  data_in;
    logic [1:0]  slot_sel;
    logic [11:0] read_addr;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_out;
    logic [1:0]  slot_out;
    logic [12:0] length_out;
    logic        last_byte;
  } rsp_t;

  // classified command between front and back
  typedef struct packed {
    req_t item;
    logic bad;
    logic pass;
  } cmd_t;

endpackage

@@ rtl/core/fra_queue.sv @@
// Small first-in first-out queue of any packed type.
// Depends on nothing; DEPTH must be a power of two.
module fra_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  T                           din,
  output logic                       full,
  input  logic                       pop,
  output T                           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  T                entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [LW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == LW'(DEPTH));
  assign empty   = (count == '0);
  assign level   = count;
  assign dout    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= din;
  end
endmodule

@@ rtl/core/fra_front.sv @@
// Front end: validates fragment headers and classifies each request.
// Depends on fra_pkg.
module fra_front #(
  parameter int STORE_BYTES = fra_pkg::STORE_BYTES_DEF
) (
  input  fra_pkg::req_t req,
  output fra_pkg::cmd_t cmd
);
  import fra_pkg::*;

  logic [31:0] payload_len;
  logic        size_bad;
  logic        total_bad;
  logic        order_bad;
  logic        range_bad;

  // header sanity checks, all in parallel
  assign payload_len = {16'b0, req.frag_len} - 32'(HDR_BYTES);
  assign size_bad    = (req.frag_size != payload_len);
  assign total_bad   = (req.msg_total > 32'(STORE_BYTES));
  assign order_bad   = (req.frag_size > req.msg_total);
  assign range_bad   = ((req.msg_total - req.frag_size) < req.frag_offset);

  always_comb begin
    cmd.item = req;
    cmd.bad  = size_bad || total_bad || order_bad || range_bad;
    cmd.pass = (req.frag_size == req.msg_total);
  end
endmodule

@@ rtl/core/fra_back.sv @@
// Back end: slot table, byte store and result generation.
// Depends on fra_pkg.
module fra_back #(
  parameter int SLOT_COUNT  = fra_pkg::SLOT_COUNT_DEF,
  parameter int STORE_BYTES = fra_pkg::STORE_BYTES_DEF,
  parameter int OUT_DEPTH   = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fra_pkg::cmd_t                  cmd,
  input  logic                           cmd_empty,
  output logic                           cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
  output logic                           out_push,
  output fra_pkg::rsp_t                  out_item
);
  import fra_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int POS_W  = $clog2(STORE_BYTES);
  localparam int LEN_W  = $clog2(STORE_BYTES + 1);
  localparam int MEM_D  = SLOT_COUNT * STORE_BYTES;
  localparam int AW     = $clog2(MEM_D);
  localparam int OLW    = $clog2(OUT_DEPTH + 1);

  // slot table
  logic              slot_used      [SLOT_COUNT];
  logic [31:0]       slot_seq       [SLOT_COUNT];
  logic [31:0]       slot_fill      [SLOT_COUNT];
  logic              slot_used_next [SLOT_COUNT];
  logic [31:0]       slot_seq_next  [SLOT_COUNT];
  logic [31:0]       slot_fill_next [SLOT_COUNT];

  // current fragment stream
  logic [SLOT_W-1:0] active_slot, active_slot_next;
  logic [LEN_W-1:0]  bytes_left,  bytes_left_next;
  logic [POS_W-1:0]  write_pos,   write_pos_next;
  logic              pass_mode,   pass_mode_next;
  logic [LEN_W-1:0]  cur_size,    cur_size_next;
  logic [LEN_W-1:0]  cur_total,   cur_total_next;

  // byte store
  logic [7:0]        store [MEM_D];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [7:0]        mem_rdata;

  // result stage, registered after execution to meet the store read
  logic              pend_valid;
  rsp_t              pend_item;
  logic              pend_rd;
  logic              pend_zero;

  logic              res_valid;
  rsp_t              res_item;
  logic              res_rd;
  logic              res_zero;

  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              free_ok;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] tgt;
  logic [31:0]       fill_sum;
  logic [SLOT_W-1:0] sel_idx;
  logic              sel_ok;
  logic              addr_ok;

  // issue only when the result queue has room for everything in flight
  assign cmd_pop = !cmd_empty &&
                   ((OLW+1)'(out_level) + (OLW+1)'(pend_valid) < (OLW+1)'(OUT_DEPTH));

  assign sel_idx = SLOT_W'(cmd.item.slot_sel);
  assign sel_ok  = ({30'b0, cmd.item.slot_sel} < 32'(SLOT_COUNT));
  assign addr_ok = ({20'b0, cmd.item.read_addr} < 32'(STORE_BYTES));

  // slot search: first used slot with matching sequence, first free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_ok  = 1'b1;
        free_idx = SLOT_W'(i);
      end else if (slot_seq[i] == cmd.item.seq_id) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign mem_waddr = AW'(active_slot) * AW'(STORE_BYTES) + AW'(write_pos);
  assign mem_raddr = AW'(cmd.item.slot_sel) * AW'(STORE_BYTES) + AW'(cmd.item.read_addr);

  // command execution
  always_comb begin
    slot_used_next   = slot_used;
    slot_seq_next    = slot_seq;
    slot_fill_next   = slot_fill;
    active_slot_next = active_slot;
    bytes_left_next  = bytes_left;
    write_pos_next   = write_pos;
    pass_mode_next   = pass_mode;
    cur_size_next    = cur_size;
    cur_total_next   = cur_total;
    res_valid        = 1'b0;
    res_item         = '0;
    res_rd           = 1'b0;
    res_zero         = 1'b0;
    mem_we           = 1'b0;
    tgt              = hit ? hit_idx : free_idx;
    fill_sum         = '0;
    if (cmd_pop) begin
      case (cmd.item.op)
        OP_HEADER: begin
          bytes_left_next = '0;
          pass_mode_next  = 1'b0;
          if (cmd.bad) begin
            res_valid     = 1'b1;
            res_item.kind = KIND_BAD_HDR;
          end else if (cmd.pass) begin
            pass_mode_next      = 1'b1;
            bytes_left_next     = LEN_W'(cmd.item.frag_size);
            write_pos_next      = '0;
            cur_size_next       = LEN_W'(cmd.item.frag_size);
            cur_total_next      = LEN_W'(cmd.item.msg_total);
            res_valid           = 1'b1;
            res_item.kind       = KIND_WHOLE;
            res_item.length_out = 13'(cmd.item.msg_total);
          end else if (!hit && !free_ok) begin
            res_valid     = 1'b1;
            res_item.kind = KIND_NO_SLOT;
          end else begin
            if (!hit) begin
              slot_used_next[tgt] = 1'b1;
              slot_fill_next[tgt] = '0;
              slot_seq_next[tgt]  = cmd.item.seq_id;
            end
            active_slot_next = tgt;
            cur_size_next    = LEN_W'(cmd.item.frag_size);
            cur_total_next   = LEN_W'(cmd.item.msg_total);
            write_pos_next   = POS_W'(cmd.item.frag_offset);
            if (cmd.item.frag_size == '0) begin
              // empty fragment settles at once
              fill_sum  = hit ? slot_fill[tgt] : '0;
              res_valid = 1'b1;
              res_item.slot_out = 2'(tgt);
              if (fill_sum == 32'(cmd.item.msg_total)) begin
                res_item.kind       = KIND_COMPLETE;
                res_item.length_out = 13'(cmd.item.msg_total);
              end else begin
                res_item.kind = KIND_STORED;
              end
            end else begin
              bytes_left_next = LEN_W'(cmd.item.frag_size);
            end
          end
        end
        OP_BYTE: begin
          if (bytes_left != '0) begin
            if (pass_mode) begin
              bytes_left_next    = bytes_left - 1'b1;
              res_valid          = 1'b1;
              res_item.kind      = KIND_PASS;
              res_item.data_out  = cmd.item.data_in;
              res_item.last_byte = (bytes_left == LEN_W'(1));
            end else if (!slot_used[active_slot]) begin
              // slot released under the stream
              bytes_left_next = '0;
            end else begin
              mem_we          = 1'b1;
              write_pos_next  = write_pos + 1'b1;
              bytes_left_next = bytes_left - 1'b1;
              if (bytes_left == LEN_W'(1)) begin
                fill_sum                    = slot_fill[active_slot] + 32'(cur_size);
                slot_fill_next[active_slot] = fill_sum;
                res_valid                   = 1'b1;
                res_item.slot_out           = 2'(active_slot);
                if (fill_sum == 32'(cur_total)) begin
                  res_item.kind       = KIND_COMPLETE;
                  res_item.length_out = 13'(cur_total);
                end else begin
                  res_item.kind = KIND_STORED;
                end
              end
            end
          end
        end
        OP_READ: begin
          res_valid     = 1'b1;
          res_item.kind = KIND_READ;
          res_rd        = 1'b1;
          res_zero      = !(sel_ok && addr_ok);
        end
        OP_RELEASE: begin
          if (sel_ok) slot_used_next[sel_idx] = 1'b0;
          res_valid         = 1'b1;
          res_item.kind     = KIND_RELEASED;
          res_item.slot_out = cmd.item.slot_sel;
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_used[i] <= 1'b0;
      active_slot <= '0;
      bytes_left  <= '0;
      write_pos   <= '0;
      pass_mode   <= 1'b0;
      cur_size    <= '0;
      cur_total   <= '0;
      pend_valid  <= 1'b0;
    end else begin
      slot_used   <= slot_used_next;
      active_slot <= active_slot_next;
      bytes_left  <= bytes_left_next;
      write_pos   <= write_pos_next;
      pass_mode   <= pass_mode_next;
      cur_size    <= cur_size_next;
      cur_total   <= cur_total_next;
      pend_valid  <= res_valid;
    end
  end

  // slot payload registers and result stage data
  always_ff @(posedge clk) begin
    slot_seq  <= slot_seq_next;
    slot_fill <= slot_fill_next;
    pend_item <= res_item;
    pend_rd   <= res_rd;
    pend_zero <= res_zero;
  end

  // byte store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= cmd.item.data_in;
    mem_rdata <= store[mem_raddr];
  end

  // hand the finished result to the output queue
  always_comb begin
    out_push = pend_valid;
    out_item = pend_item;
    if (pend_rd) out_item.data_out = pend_zero ? 8'h00 : mem_rdata;
  end
endmodule

@@ rtl/core/fragment_reassembly_slots.sv @@
// Top level of the fragment reassembly block: front, command queue, back, result queue.
// Depends on fra_pkg, fra_front, fra_queue, fra_back and the defines header.
//
//   channel  | handshake         | payload
//   ---------+-------------------+----------------
//   request  | push / full       | req   (req_t)
//   result   | pop / empty       | rsp   (rsp_t)
//
// The back end executes one request per cycle while the result queue has room; it
// sustains one item a cycle while the result queue drains. A request is registered in the
// command queue, its result in the result stage and then in the result queue.
// Reset clears the slot table in-use flags and both queues; stored bytes,
// sequence numbers and fill counts stay undefined until written.
// A stalled consumer fills the result queue, then the command queue, then full rises.
`include "fragment_reassembly_slots_defines.svh"
module fragment_reassembly_slots #(
  parameter int SLOT_COUNT  = fra_pkg::SLOT_COUNT_DEF,
  parameter int STORE_BYTES = fra_pkg::STORE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  fra_pkg::req_t req,
  input  logic          pop,
  output logic          empty,
  output fra_pkg::rsp_t rsp
);
  import fra_pkg::*;

  localparam int CQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;

  cmd_t                          front_cmd;
  cmd_t                          head_cmd;
  logic                          cq_empty;
  logic [$clog2(CQ_DEPTH+1)-1:0] cq_level;
  logic                          cmd_pop;
  logic                          out_push;
  rsp_t                          out_item;
  logic                          oq_full;
  logic [$clog2(OQ_DEPTH+1)-1:0] oq_level;

  // classify incoming requests
  fra_front #(.STORE_BYTES(STORE_BYTES)) u_front (
    .req (req),
    .cmd (front_cmd)
  );

  // decouples front from back
  fra_queue #(.T(cmd_t), .DEPTH(CQ_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (head_cmd),
    .empty (cq_empty),
    .level (cq_level)
  );

  // execute commands
  fra_back #(
    .SLOT_COUNT  (SLOT_COUNT),
    .STORE_BYTES (STORE_BYTES),
    .OUT_DEPTH   (OQ_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .cmd_empty (cq_empty),
    .cmd_pop   (cmd_pop),
    .out_level (oq_level),
    .out_push  (out_push),
    .out_item  (out_item)
  );

  // results waiting for the consumer
  fra_queue #(.T(rsp_t), .DEPTH(OQ_DEPTH)) u_rsp_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_item),
    .full  (oq_full),
    .pop   (pop),
    .dout  (rsp),
    .empty (empty),
    .level (oq_level)
  );

  // checks
  `FRA_ASSERT_NOW(a_pop_has_cmd, cmd_pop, !cq_empty)
  `FRA_ASSERT_NOW(a_no_rsp_overflow, out_push, !oq_full)
  `FRA_ASSERT_NEXT(a_rsp_lands, out_push && !pop, !empty)
  `FRA_ASSERT_NEXT(a_cmd_lands, push && !full && !cmd_pop, !cq_empty)
  `FRA_ASSERT_NOW(a_full_level, full, cq_level == ($clog2(CQ_DEPTH+1))'(CQ_DEPTH))
endmodule
